[design/h264nsc_pkg.sv]
// Package: shared types and constants for the NAL start code framer.
`default_nettype none
package h264nsc_pkg;
    localparam logic [4:0] NAL_IDR       = 5'd5;
    localparam logic [4:0] NAL_SPS       = 5'd7;
    localparam logic [4:0] NAL_PPS       = 5'd8;
    localparam logic [4:0] NAL_AUD       = 5'd9;
    localparam logic [7:0] NAL_TYPE_MASK = 8'h1f;

    typedef enum logic [2:0] {
        ST_IN   = 3'b001,
        ST_SEQ  = 3'b010,
        ST_PIC  = 3'b100
    } t_state;

    // One emitted byte with its marks.
    typedef struct packed {
        logic [7:0]  data;
        logic        first;
        logic        last;
        logic [63:0] stamp;
        logic [4:0]  kind;
    } t_beat;
endpackage
`default_nettype wire

[design/h264nsc_ram.sv]
// Generic single-port-write, registered-read RAM.
`default_nettype none
module h264nsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[design/h264_nal_start_code_framer.sv]
// Top level: Annex B start code framer with SPS/PPS replay in front of IDR.
//
// Bytes enter one per transaction through a seven-byte delay line; a start
// code 00 00 00 01 is recognized when the byte after its type byte arrives.
// SPS and PPS units are captured into two RAMs (SEQ_DEPTH / PIC_DEPTH bytes)
// and not passed on. Each emitted IDR is preceded by the stored SPS then PPS,
// read back from the RAMs one byte per cycle while the output is not stalled.
// A byte that is dropped or stored does not hold the input; after a byte that
// is passed on the input waits until the output register is empty, and after
// a byte that opens an emitted IDR it also waits for the replay sequencer,
// reading through the single RAM read port of each store, and for the output
// register to drain. The input stalls while the output register holds a byte,
// a RAM read is in flight or a replay runs. Results carry first/last marks,
// the NAL type and the timestamp latched at the start code when it is nonzero
// with bit 63 clear. The last unit of the stream is never closed.
`default_nettype none
module h264_nal_start_code_framer
    import h264nsc_pkg::*;
#(
    parameter int SEQ_DEPTH = 32,
    parameter int PIC_DEPTH = 16
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_valid,
    output logic         o_stall,
    input  wire  [7:0]   i_data_byte,
    input  wire  [63:0]  i_stamp,
    output logic         o_valid,
    input  wire          i_stall,
    output logic [7:0]   o_out_byte,
    output logic         o_frame_first,
    output logic         o_frame_last,
    output logic [63:0]  o_frame_stamp,
    output logic [4:0]   o_nal_kind
);
    localparam int SAW = $clog2(SEQ_DEPTH);
    localparam int PAW = $clog2(PIC_DEPTH);
    localparam int SLW = $clog2(SEQ_DEPTH + 1);
    localparam int PLW = $clog2(PIC_DEPTH + 1);

    t_state r_state;
    logic [7:0]  r_dly [7];
    logic [2:0]  r_fill;
    logic [SLW-1:0] r_seq_len, r_sidx;
    logic [PLW-1:0] r_pic_len, r_pidx;
    logic        r_seen, r_drop, r_emit, r_fpend;
    logic [4:0]  r_kind;
    logic [63:0] r_stamp;
    logic        r_rd;           // a RAM read is in flight, data not yet in the output register
    logic        r_rd_last;      // that read was the last replay byte
    logic        r_ov;
    t_beat       r_ob;

    logic        acc, found, old_ok, out_free, issue;
    logic [7:0]  oldest;
    logic [4:0]  nk;
    logic [7:0]  seq_q, pic_q;
    logic        seq_we, pic_we;
    logic [SLW-1:0] seq_ra;
    logic [PLW-1:0] pic_ra;

    // Output slot is free if empty or being taken this cycle.
    assign out_free = !r_ov || !i_stall;
    assign o_stall  = (r_state != ST_IN) || r_rd || r_ov;
    assign acc      = i_valid && !o_stall;
    // Replay issues one read per free output slot.
    assign issue    = (r_state != ST_IN) && (!r_rd || out_free);

    // Window after shifting the new byte in: positions 1..6 = r_dly[2..6], byte.
    assign found  = (r_fill >= 3'd5) && r_dly[2] == 8'd0 && r_dly[3] == 8'd0
                    && r_dly[4] == 8'd0 && r_dly[5] == 8'd1;
    assign oldest = r_dly[1];
    assign nk     = r_dly[6][4:0] & NAL_TYPE_MASK[4:0];
    assign old_ok = r_seen && (r_fill >= 3'd6);

    assign seq_we = acc && old_ok && r_kind == NAL_SPS && r_seq_len < SLW'(SEQ_DEPTH);
    assign pic_we = acc && old_ok && r_kind == NAL_PPS && r_pic_len < PLW'(PIC_DEPTH);

    // Without a new issue the pending address is read again, so RAM data
    // holds while the output is stalled.
    assign seq_ra = (issue && r_state == ST_SEQ) ? r_sidx : r_sidx - 1'b1;
    assign pic_ra = (issue && r_state == ST_PIC) ? r_pidx : r_pidx - 1'b1;

    h264nsc_ram #(.WIDTH(8), .DEPTH(SEQ_DEPTH)) u_seq (
        .i_clk(i_clk), .i_we(seq_we), .i_waddr(r_seq_len[SAW-1:0]),
        .i_wdata(oldest), .i_raddr(seq_ra[SAW-1:0]), .o_rdata(seq_q));
    h264nsc_ram #(.WIDTH(8), .DEPTH(PIC_DEPTH)) u_pic (
        .i_clk(i_clk), .i_we(pic_we), .i_waddr(r_pic_len[PAW-1:0]),
        .i_wdata(oldest), .i_raddr(pic_ra[PAW-1:0]), .o_rdata(pic_q));

    logic r_rd_seq;
    logic r_rd_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IN;  r_fill <= '0;
            r_seq_len <= '0;   r_pic_len <= '0;
            r_sidx <= '0;      r_pidx <= '0;
            r_seen <= 1'b0;    r_drop <= 1'b1;  r_emit <= 1'b0;
            r_fpend <= 1'b0;   r_kind <= '0;    r_stamp <= '0;
            r_rd <= 1'b0;      r_rd_last <= 1'b0; r_ov <= 1'b0;
            r_rd_seq <= 1'b0;  r_rd_first <= 1'b0;
        end else begin
            if (r_ov && !i_stall) r_ov <= 1'b0;
            // Replayed RAM data lands in the output register.
            if (r_rd && out_free) begin
                r_ov <= 1'b1;
                r_ob <= '{data: r_rd_seq ? seq_q : pic_q, first: r_rd_first,
                          last: 1'b0, stamp: r_stamp, kind: r_kind};
                r_rd <= 1'b0;
                if (r_rd_last) r_fpend <= 1'b0;
            end
            // Replay sequencer.
            if (issue) begin
                r_rd <= 1'b1;
                if (r_state == ST_SEQ) begin
                    r_rd_seq <= 1'b1;
                    r_rd_first <= r_sidx == '0;
                    r_rd_last <= 1'b0;
                    if (r_sidx + 1'b1 == r_seq_len) r_state <= ST_PIC;
                    r_sidx <= r_sidx + 1'b1;
                end else begin
                    r_rd_seq <= 1'b0;
                    r_rd_first <= r_seq_len == '0 && r_pidx == '0;
                    r_rd_last <= r_pidx + 1'b1 == r_pic_len;
                    if (r_pidx + 1'b1 == r_pic_len) r_state <= ST_IN;
                    r_pidx <= r_pidx + 1'b1;
                end
            end
            if (acc) begin
                for (int k = 0; k < 6; k++) r_dly[k] <= r_dly[k+1];
                r_dly[6] <= i_data_byte;
                if (r_fill != 3'd7) r_fill <= r_fill + 1'b1;
                if (seq_we) r_seq_len <= r_seq_len + 1'b1;
                if (pic_we) r_pic_len <= r_pic_len + 1'b1;
                if (old_ok && r_emit) begin
                    r_ov <= 1'b1;
                    r_ob <= '{data: oldest, first: r_fpend, last: found,
                              stamp: r_stamp, kind: r_kind};
                    r_fpend <= 1'b0;
                end
                if (found) begin
                    r_seen <= 1'b1;
                    r_kind <= nk;
                    r_fpend <= 1'b0;
                    if (!i_stamp[63] && i_stamp != '0) r_stamp <= i_stamp;
                    unique case (1'b1)
                        nk == NAL_SPS: begin
                            r_seq_len <= '0; r_emit <= 1'b0;
                        end
                        nk == NAL_PPS: begin
                            r_pic_len <= '0; r_emit <= 1'b0;
                        end
                        nk == NAL_AUD: r_emit <= 1'b0;
                        nk == NAL_IDR: begin
                            if (r_seq_len != '0 && r_pic_len != '0) begin
                                r_drop <= 1'b0; r_emit <= 1'b1;
                                // Replay carries the first mark.
                                r_fpend <= 1'b1;
                                r_sidx <= '0; r_pidx <= '0;
                                r_state <= ST_SEQ;
                            end else begin
                                r_emit <= !r_drop;
                                r_fpend <= !r_drop;
                                r_sidx <= '0; r_pidx <= '0;
                                if (!r_drop) r_state <= ST_SEQ;
                            end
                        end
                        default: begin
                            r_emit <= !r_drop; r_fpend <= !r_drop;
                        end
                    endcase
                end
            end
        end
    end

    assign o_valid       = r_ov;
    assign o_out_byte    = r_ob.data;
    assign o_frame_first = r_ob.first;
    assign o_frame_last  = r_ob.last;
    assign o_frame_stamp = r_ob.stamp;
    assign o_nal_kind    = r_ob.kind;

    a_no_acc_in_replay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IN) |-> !acc) else $error("input taken during replay");
    a_len_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seq_len <= SLW'(SEQ_DEPTH)) else $error("seq length overflow");
    a_len_pic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pic_len <= PLW'(PIC_DEPTH)) else $error("pic length overflow");
endmodule
`default_nettype wire
